// ===== hdl/rmlc_pkg.sv =====
package rmlc_pkg;

    localparam int WINDOW_DEFAULT      = 20;
    localparam int SAMPLE_BITS_DEFAULT = 16;

    // ratio registers are q8.8
    localparam int RATIO_BITS = 16;
    localparam int RATIO_FRAC = 8;

    localparam logic [RATIO_BITS-1:0] HIGH_RATIO_RESET = 16'd307;
    localparam logic [RATIO_BITS-1:0] LOW_RATIO_RESET  = 16'd205;

    localparam int CFG_INDEX_BITS = 1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_HIGH_RATIO = 1'b0,
        REG_LOW_RATIO  = 1'b1
    } cfg_reg_t;

    localparam int OUT_TDATA_BITS = 8;

endpackage

// ===== hdl/rolling_median_level_classifier.sv =====
// Rolling-median level classifier. Each stream transaction carries one unsigned sample;
// each produces one result transaction with level_high in bit 0 and level_low in bit 1.
// The first WINDOW samples only fill the window store (both flags 0).
// After that the upper median of the previous WINDOW samples is found by rank counting
// over a window memory with separate read and write ports: each candidate is compared
// with every stored entry and the search stops at the first candidate of the median
// rank. One shared multiplier then scales the median by the high and, when the high
// test fails, the low q8.8 ratio. A result waits in S_WRITE until the output register
// is free. s_tready is high only between items; a finished result may wait in the
// output register while the next sample is accepted. Ratio registers are written through
// cfg_wr_en/cfg_index/cfg_wdata; the user must write them only while the block is idle,
// as the block itself does not enforce this.
module rolling_median_level_classifier
    import rmlc_pkg::*;
#(
    parameter int WINDOW      = WINDOW_DEFAULT,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,   // [SAMPLE_BITS-1:0] sample

    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [OUT_TDATA_BITS-1:0]           m_tdata,   // [0] level_high, [1] level_low

    input  logic                                cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0]           cfg_index,
    input  logic [RATIO_BITS-1:0]               cfg_wdata
);

    localparam int IDX_W  = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int RANK   = WINDOW / 2;
    localparam int PROD_W = SAMPLE_BITS + RATIO_BITS;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_FETCH_V = 10'b00_0000_0010,
        S_LATCH   = 10'b00_0000_0100,
        S_SCAN    = 10'b00_0000_1000,
        S_RANK    = 10'b00_0001_0000,
        S_MUL_HI  = 10'b00_0010_0000,
        S_CMP_HI  = 10'b00_0100_0000,
        S_MUL_LO  = 10'b00_1000_0000,
        S_CMP_LO  = 10'b01_0000_0000,
        S_WRITE   = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [RATIO_BITS-1:0]  high_ratio_reg, low_ratio_reg;
    logic [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic [SAMPLE_BITS-1:0] cand_reg, cand_next;
    logic [SAMPLE_BITS-1:0] med_reg, med_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic [IDX_W-1:0]       cand_idx_reg, cand_idx_next;
    logic [IDX_W-1:0]       scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]       below_reg, below_next;
    logic [CNT_W-1:0]       at_below_reg, at_below_next;
    logic [IDX_W-1:0]       write_slot_reg, write_slot_next;
    logic [CNT_W-1:0]       fill_count_reg, fill_count_next;
    logic                   hi_reg, hi_next;
    logic                   lo_reg, lo_next;
    logic                   m_valid_reg, m_valid_next;
    logic                   out_hi_reg, out_hi_next;
    logic                   out_lo_reg, out_lo_next;

    logic                   ram_wr_en;
    logic [IDX_W-1:0]       ram_rd_addr;
    logic [SAMPLE_BITS-1:0] ram_rd_data;
    logic [RATIO_BITS-1:0]  ratio_sel;
    logic [PROD_W-1:0]      scaled;
    logic                   out_free;

    rmlc_window_ram #(
        .DEPTH (WINDOW),
        .WIDTH (SAMPLE_BITS)
    ) u_window_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (write_slot_reg),
        .wr_data (sample_reg),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_ratio_reg <= HIGH_RATIO_RESET;
            low_ratio_reg  <= LOW_RATIO_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_HIGH_RATIO: high_ratio_reg <= cfg_wdata;
                REG_LOW_RATIO:  low_ratio_reg  <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(OUT_TDATA_BITS-2){1'b0}}, out_lo_reg, out_hi_reg};
    assign out_free  = !m_valid_reg || m_tready;
    assign ram_wr_en = (state_reg == S_WRITE) && out_free;

    // shared multiplier operand and the sample scaled to q.8
    assign ratio_sel = (state_reg == S_MUL_HI) ? high_ratio_reg : low_ratio_reg;
    assign scaled    = {{(RATIO_BITS-RATIO_FRAC){1'b0}}, sample_reg, {RATIO_FRAC{1'b0}}};

    always_comb begin
        unique case (state_reg)
            S_FETCH_V: ram_rd_addr = cand_idx_reg;
            S_SCAN:    ram_rd_addr = (scan_idx_reg == IDX_W'(WINDOW - 1)) ?
                                     '0 : scan_idx_reg + 1'b1;
            default:   ram_rd_addr = '0;
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        sample_next     = sample_reg;
        cand_next       = cand_reg;
        med_next        = med_reg;
        prod_next       = prod_reg;
        cand_idx_next   = cand_idx_reg;
        scan_idx_next   = scan_idx_reg;
        below_next      = below_reg;
        at_below_next   = at_below_reg;
        write_slot_next = write_slot_reg;
        fill_count_next = fill_count_reg;
        hi_next         = hi_reg;
        lo_next         = lo_reg;
        m_valid_next    = m_valid_reg;
        out_hi_next     = out_hi_reg;
        out_lo_next     = out_lo_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    sample_next   = s_tdata[SAMPLE_BITS-1:0];
                    hi_next       = 1'b0;
                    lo_next       = 1'b0;
                    cand_idx_next = '0;
                    if (fill_count_reg == CNT_W'(WINDOW)) begin
                        state_next = S_FETCH_V;
                    end else begin
                        state_next = S_WRITE;
                    end
                end
            end
            S_FETCH_V: begin
                state_next = S_LATCH;
            end
            S_LATCH: begin
                cand_next     = ram_rd_data;
                scan_idx_next = '0;
                below_next    = '0;
                at_below_next = '0;
                state_next    = S_SCAN;
            end
            S_SCAN: begin
                if (ram_rd_data < cand_reg) begin
                    below_next = below_reg + 1'b1;
                end
                if (ram_rd_data <= cand_reg) begin
                    at_below_next = at_below_reg + 1'b1;
                end
                scan_idx_next = scan_idx_reg + 1'b1;
                if (scan_idx_reg == IDX_W'(WINDOW - 1)) begin
                    state_next = S_RANK;
                end
            end
            S_RANK: begin
                // candidate sits at the median rank when its tie run covers it
                if (below_reg <= CNT_W'(RANK) && CNT_W'(RANK) < at_below_reg) begin
                    med_next   = cand_reg;
                    state_next = S_MUL_HI;
                end else begin
                    cand_idx_next = cand_idx_reg + 1'b1;
                    state_next    = S_FETCH_V;
                end
            end
            S_MUL_HI: begin
                prod_next  = PROD_W'(med_reg) * PROD_W'(ratio_sel);
                state_next = S_CMP_HI;
            end
            S_CMP_HI: begin
                if (scaled > prod_reg) begin
                    hi_next    = 1'b1;
                    state_next = S_WRITE;
                end else begin
                    state_next = S_MUL_LO;
                end
            end
            S_MUL_LO: begin
                prod_next  = PROD_W'(med_reg) * PROD_W'(ratio_sel);
                state_next = S_CMP_LO;
            end
            S_CMP_LO: begin
                lo_next    = (scaled < prod_reg);
                state_next = S_WRITE;
            end
            S_WRITE: begin
                // store the sample over the oldest entry and hand the result over
                if (out_free) begin
                    m_valid_next = 1'b1;
                    out_hi_next  = hi_reg;
                    out_lo_next  = lo_reg;
                    if (write_slot_reg == IDX_W'(WINDOW - 1)) begin
                        write_slot_next = '0;
                    end else begin
                        write_slot_next = write_slot_reg + 1'b1;
                    end
                    if (fill_count_reg != CNT_W'(WINDOW)) begin
                        fill_count_next = fill_count_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            write_slot_reg <= '0;
            fill_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            write_slot_reg <= write_slot_next;
            fill_count_reg <= fill_count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg   <= sample_next;
        cand_reg     <= cand_next;
        med_reg      <= med_next;
        prod_reg     <= prod_next;
        cand_idx_reg <= cand_idx_next;
        scan_idx_reg <= scan_idx_next;
        below_reg    <= below_next;
        at_below_reg <= at_below_next;
        hi_reg       <= hi_next;
        lo_reg       <= lo_next;
        out_hi_reg   <= out_hi_next;
        out_lo_reg   <= out_lo_next;
    end

endmodule

// ===== hdl/rmlc_window_ram.sv =====
module rmlc_window_ram
    import rmlc_pkg::*;
#(
    parameter int DEPTH = WINDOW_DEFAULT,
    parameter int WIDTH = SAMPLE_BITS_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
